// ===== rtl/tgarle_pkg.sv =====
// Package for the TGA run-length decoder.
// Holds widths, register indexes, the count unit result type and the pixel size helper.
// No dependencies.
`default_nettype none

package tgarle_pkg;

  localparam int MAX_PIXEL_BYTES = 4;
  localparam int BYTE_W          = 8;
  localparam int PIX_W           = 32;
  localparam int CNT_W           = 8;
  localparam int REM_W           = 32;
  localparam int BPP_W           = 3;
  localparam int POS_W           = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int TAKE_W          = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BPP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd1;

  localparam int PKT_TYPE_BIT = 7;
  localparam int PKT_COUNT_W  = 7;

  localparam logic [BPP_W-1:0] BPP_RESET   = 3'd3;
  localparam logic [REM_W-1:0] TOTAL_RESET = 32'd1;

  typedef struct packed {
    logic [TAKE_W-1:0] take;
    logic [CNT_W-1:0]  cnt_nxt;
    logic [REM_W-1:0]  rem_nxt;
    logic              cnt_zero;
    logic              rem_zero;
  } count_res_t;

  function automatic logic [BPP_W-1:0] pix_bytes(input logic [BPP_W-1:0] bpp);
    logic [BPP_W-1:0] b;
    b = bpp;
    if (b == '0) begin
      b = BPP_W'(1);
    end else if (b > BPP_W'(MAX_PIXEL_BYTES)) begin
      b = BPP_W'(MAX_PIXEL_BYTES);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tgarle_count_unit.sv =====
// Shared pixel count unit: picks the beat size and steps the packet and image counters.
// Used for literal beats and for every beat of a run expansion.
// Depends on tgarle_pkg.
`default_nettype none

module tgarle_count_unit (
  input  logic                         lit,
  input  logic [tgarle_pkg::CNT_W-1:0] cnt,
  input  logic [tgarle_pkg::REM_W-1:0] rem,
  output tgarle_pkg::count_res_t       res
);
  import tgarle_pkg::*;

  logic two_ok;

  always_comb begin
    two_ok       = !lit && (cnt >= CNT_W'(2)) && (rem >= REM_W'(2));
    res.take     = two_ok ? TAKE_W'(2) : TAKE_W'(1);
    res.cnt_nxt  = cnt - CNT_W'(res.take);
    res.rem_nxt  = rem - REM_W'(res.take);
    res.cnt_zero = (res.cnt_nxt == '0);
    res.rem_zero = (res.rem_nxt == '0);
  end

endmodule

`default_nettype wire

// ===== rtl/tga_rle_decoder.sv =====
// Top level of the TGA run-length decoder.
// Byte intake, packet sequencer and output register; uses tgarle_count_unit and tgarle_pkg.
`default_nettype none

// Takes one compressed byte per request and emits beats of one or two pixels. A header
// byte or a partial pixel byte gives no beat; the byte that ends a literal pixel gives
// one beat. After the byte that ends a run pixel, the shared count unit emits one beat
// per cycle while out_ready allows, up to two copies at a time; in_ready stays low
// meanwhile and whenever a low out_ready holds a finished beat in the output register. A
// configuration write to REG_BPP or REG_TOTAL restarts decoding at a packet header and
// reloads the pixel total.

module tga_rle_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tgarle_pkg::BYTE_W-1:0]     in_data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tgarle_pkg::PIX_W-1:0]      out_pixel_first,
  output logic [tgarle_pkg::PIX_W-1:0]      out_pixel_second,
  output logic [1:0]                        out_pixel_count,
  output logic                              out_run_last,
  output logic                              out_image_done,
  input  logic                              cfg_we,
  input  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tgarle_pkg::*;

  localparam logic ST_IN  = 1'b0;
  localparam logic ST_RUN = 1'b1;

  logic              state_r, state_nxt;
  logic [BPP_W-1:0]  bpp_r, bpp_nxt;
  logic [REM_W-1:0]  total_r, total_nxt;
  logic              hdr_r, hdr_nxt;
  logic              is_run_r, is_run_nxt;
  logic [CNT_W-1:0]  pkt_cnt_r, pkt_cnt_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [PIX_W-1:0]  acc_r, acc_nxt;
  logic [PIX_W-1:0]  run_pix_r, run_pix_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;

  logic              ov_r, ov_nxt;
  logic [PIX_W-1:0]  o_first_r, o_first_nxt;
  logic [PIX_W-1:0]  o_second_r, o_second_nxt;
  logic [1:0]        o_count_r, o_count_nxt;
  logic              o_last_r, o_last_nxt;
  logic              o_done_r, o_done_nxt;

  logic              out_free;
  logic              accept;
  logic              cu_lit;
  count_res_t        cu_res;
  logic [PIX_W-1:0]  pix_val;
  logic              pix_end;

  tgarle_count_unit u_count (
    .lit (cu_lit),
    .cnt (pkt_cnt_r),
    .rem (rem_r),
    .res (cu_res)
  );

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == ST_IN) && out_free;
  assign accept   = in_valid && in_ready;
  assign cu_lit   = (state_r == ST_IN);
  assign pix_val  = acc_r | (PIX_W'(in_data_byte) << {pos_r, 3'b000});
  assign pix_end  = ({1'b0, pos_r} + BPP_W'(1)) >= pix_bytes(bpp_r);

  always_comb begin
    state_nxt    = state_r;
    bpp_nxt      = bpp_r;
    total_nxt    = total_r;
    hdr_nxt      = hdr_r;
    is_run_nxt   = is_run_r;
    pkt_cnt_nxt  = pkt_cnt_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    run_pix_nxt  = run_pix_r;
    rem_nxt      = rem_r;
    ov_nxt       = ov_r && !out_ready;
    o_first_nxt  = o_first_r;
    o_second_nxt = o_second_r;
    o_count_nxt  = o_count_r;
    o_last_nxt   = o_last_r;
    o_done_nxt   = o_done_r;

    unique case (state_r)
      ST_IN: begin
        if (accept && (rem_r != '0)) begin
          if (hdr_r) begin
            is_run_nxt  = in_data_byte[PKT_TYPE_BIT];
            pkt_cnt_nxt = CNT_W'(in_data_byte[PKT_COUNT_W-1:0]) + CNT_W'(1);
            pos_nxt     = '0;
            acc_nxt     = '0;
            hdr_nxt     = 1'b0;
          end else if (!pix_end) begin
            acc_nxt = pix_val;
            pos_nxt = pos_r + POS_W'(1);
          end else begin
            acc_nxt = '0;
            pos_nxt = '0;
            if (is_run_r) begin
              run_pix_nxt = pix_val;
              state_nxt   = ST_RUN;
            end else begin
              rem_nxt      = cu_res.rem_nxt;
              pkt_cnt_nxt  = cu_res.cnt_nxt;
              hdr_nxt      = cu_res.cnt_zero;
              ov_nxt       = 1'b1;
              o_first_nxt  = pix_val;
              o_second_nxt = '0;
              o_count_nxt  = 2'd1;
              o_last_nxt   = 1'b1;
              o_done_nxt   = cu_res.rem_zero;
            end
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          rem_nxt      = cu_res.rem_nxt;
          pkt_cnt_nxt  = cu_res.cnt_nxt;
          ov_nxt       = 1'b1;
          o_first_nxt  = run_pix_r;
          o_second_nxt = (cu_res.take == TAKE_W'(2)) ? run_pix_r : '0;
          o_count_nxt  = cu_res.take;
          o_last_nxt   = cu_res.cnt_zero || cu_res.rem_zero;
          o_done_nxt   = cu_res.rem_zero;
          if (cu_res.cnt_zero || cu_res.rem_zero) begin
            pkt_cnt_nxt = '0;
            hdr_nxt     = 1'b1;
            state_nxt   = ST_IN;
          end
        end
      end
      default: begin
        state_nxt = ST_IN;
      end
    endcase

    if (cfg_we && ((cfg_index == REG_BPP) || (cfg_index == REG_TOTAL))) begin
      if (cfg_index == REG_BPP) begin
        bpp_nxt = cfg_wdata[BPP_W-1:0];
        rem_nxt = total_r;
      end else begin
        total_nxt = cfg_wdata[REM_W-1:0];
        rem_nxt   = cfg_wdata[REM_W-1:0];
      end
      state_nxt   = ST_IN;
      hdr_nxt     = 1'b1;
      is_run_nxt  = 1'b0;
      pkt_cnt_nxt = '0;
      pos_nxt     = '0;
      acc_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IN;
      bpp_r     <= BPP_RESET;
      total_r   <= TOTAL_RESET;
      hdr_r     <= 1'b1;
      is_run_r  <= 1'b0;
      pkt_cnt_r <= '0;
      pos_r     <= '0;
      acc_r     <= '0;
      rem_r     <= TOTAL_RESET;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bpp_r     <= bpp_nxt;
      total_r   <= total_nxt;
      hdr_r     <= hdr_nxt;
      is_run_r  <= is_run_nxt;
      pkt_cnt_r <= pkt_cnt_nxt;
      pos_r     <= pos_nxt;
      acc_r     <= acc_nxt;
      rem_r     <= rem_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_pix_r  <= run_pix_nxt;
    o_first_r  <= o_first_nxt;
    o_second_r <= o_second_nxt;
    o_count_r  <= o_count_nxt;
    o_last_r   <= o_last_nxt;
    o_done_r   <= o_done_nxt;
  end

  assign out_valid        = ov_r;
  assign out_pixel_first  = o_first_r;
  assign out_pixel_second = o_second_r;
  assign out_pixel_count  = o_count_r;
  assign out_run_last     = o_last_r;
  assign out_image_done   = o_done_r;

endmodule

`default_nettype wire

// ===== rtl/tgarle_checker.sv =====
// Port-level checker for the TGA run-length decoder, bound to the top level.
// Depends on tgarle_pkg and tga_rle_decoder.
`default_nettype none

module tgarle_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tgarle_pkg::PIX_W-1:0]      out_pixel_first,
  input logic [tgarle_pkg::PIX_W-1:0]      out_pixel_second,
  input logic [1:0]                        out_pixel_count,
  input logic                              out_run_last,
  input logic                              out_image_done
);
  import tgarle_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_first)
      && $stable(out_pixel_count) && $stable(out_run_last))
    else $error("stalled beat changed");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_count == 2'd1) || (out_pixel_count == 2'd2))
    else $error("bad pixel count");

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pixel_count == 2'd2) |-> out_pixel_first == out_pixel_second)
    else $error("run pair differs");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pixel_count == 2'd1) |-> out_pixel_second == '0)
    else $error("unused pixel not zero");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_run_last)
    else $error("image end not last beat");

endmodule

bind tga_rle_decoder tgarle_checker u_tgarle_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for tga_rle_decoder: directed packets, then random packet streams.
// Predicts pixel beats from the byte stream and checks them in order; needs tgarle_pkg.
// Needs the RTL: rtl/tgarle_pkg.sv, rtl/tgarle_count_unit.sv and rtl/tga_rle_decoder.sv.
`default_nettype none

module tb_top;
  import tgarle_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_BYTES   = 24;
  localparam int IDLE_PCT      = 17;
  localparam int HOLD_AFTER    = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 200000;

  typedef struct packed {
    logic [PIX_W-1:0] first;
    logic [PIX_W-1:0] second;
    logic [1:0]       count;
    logic             run_last;
    logic             done;
  } pixel_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_pixel_first;
  logic [PIX_W-1:0]      out_pixel_second;
  logic [1:0]            out_pixel_count;
  logic                  out_run_last;
  logic                  out_image_done;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tga_rle_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_first  (out_pixel_first),
    .out_pixel_second (out_pixel_second),
    .out_pixel_count  (out_pixel_count),
    .out_run_last     (out_run_last),
    .out_image_done   (out_image_done),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  // decoder mirror
  logic [BPP_W-1:0] dec_bpp;
  logic [REM_W-1:0] dec_total;
  logic             dec_want_header;
  logic             dec_run;
  logic [CNT_W-1:0] dec_pkt_left;
  logic [2:0]       dec_pos;
  logic [PIX_W-1:0] dec_acc;
  logic [REM_W-1:0] dec_left_pixels;

  logic [BYTE_W-1:0] stream_bytes[$];
  pixel_beat_t       pending_beats[$];

  int   queued_bytes = 0;
  int   bytes_taken = 0;
  int   beats_seen = 0;
  int   reg_writes = 0;
  int   errors = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic byte_taken = 1'b0;
  logic calm;

  assign calm = (bytes_taken >= 60) && (bytes_taken < 130);

  function automatic logic [2:0] pixel_width();
    if (dec_bpp == 3'd0) return 3'd1;
    if (dec_bpp > 3'd4) return 3'd4;
    return dec_bpp;
  endfunction

  task automatic restart_decode();
    dec_want_header = 1'b1;
    dec_run         = 1'b0;
    dec_pkt_left    = '0;
    dec_pos         = '0;
    dec_acc         = '0;
    dec_left_pixels = dec_total;
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [PIX_W-1:0] pix;
    logic [REM_W-1:0] copies;
    logic [1:0]       take;
    pixel_beat_t      beat;
    if (dec_left_pixels == '0) return;
    if (dec_want_header) begin
      dec_run         = b[PKT_TYPE_BIT];
      dec_pkt_left    = {1'b0, b[PKT_COUNT_W-1:0]} + 8'd1;
      dec_pos         = '0;
      dec_acc         = '0;
      dec_want_header = 1'b0;
      return;
    end
    dec_acc = dec_acc | (PIX_W'(b) << (8 * dec_pos));
    dec_pos = dec_pos + 3'd1;
    if (dec_pos < pixel_width()) return;
    pix     = dec_acc;
    dec_pos = '0;
    dec_acc = '0;
    if (dec_run) begin
      copies = (REM_W'(dec_pkt_left) > dec_left_pixels) ? dec_left_pixels
                                                         : REM_W'(dec_pkt_left);
      while (copies > 0) begin
        take            = (copies > 2) ? 2'd2 : copies[1:0];
        copies          = copies - take;
        dec_left_pixels = dec_left_pixels - take;
        beat.first      = pix;
        beat.second     = (take == 2'd2) ? pix : '0;
        beat.count      = take;
        beat.run_last   = (copies == 0);
        beat.done       = (dec_left_pixels == '0);
        pending_beats.push_back(beat);
      end
      dec_pkt_left    = '0;
      dec_want_header = 1'b1;
    end else begin
      dec_left_pixels = dec_left_pixels - 1;
      beat.first      = pix;
      beat.second     = '0;
      beat.count      = 2'd1;
      beat.run_last   = 1'b1;
      beat.done       = (dec_left_pixels == '0);
      pending_beats.push_back(beat);
      if (dec_pkt_left > 0) dec_pkt_left = dec_pkt_left - CNT_W'(1);
      if (dec_pkt_left == 0) dec_want_header = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // output checks first, then the byte accepted at this edge
  always @(posedge clk) begin
    pixel_beat_t want;
    byte_taken = 1'b0;
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: beat with none expected, expected nothing, actual %h %h %0d %b %b",
                 $time, out_pixel_first, out_pixel_second, out_pixel_count,
                 out_run_last, out_image_done);
      end else begin
        want = pending_beats.pop_front();
        beats_seen++;
        check_field("pixel_first", want.first, out_pixel_first);
        check_field("pixel_second", want.second, out_pixel_second);
        check_field("pixel_count", 32'(want.count), 32'(out_pixel_count));
        check_field("run_last", 32'(want.run_last), 32'(out_run_last));
        check_field("image_done", 32'(want.done), 32'(out_image_done));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      byte_taken = 1'b1;
      bytes_taken++;
      decode_byte(in_data_byte);
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || byte_taken)) begin
      if (stream_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid     <= 1'b1;
        in_data_byte <= stream_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // beat receiver, with one long hold-off once traffic is flowing
  always @(negedge clk) begin
    if (!hold_done && beats_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    stream_bytes.push_back(b);
    queued_bytes++;
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] pix);
    for (int i = 0; i < pixel_width(); i++) push_byte(pix[8*i +: 8]);
  endtask

  task automatic push_packet(input logic is_run, input int cnt);
    push_byte({is_run, PKT_COUNT_W'(cnt - 1)});
    for (int i = 0; i < (is_run ? 1 : cnt); i++) push_pixel($urandom());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    reg_writes++;
    if (idx == REG_BPP) begin
      dec_bpp = val[BPP_W-1:0];
      restart_decode();
    end else if (idx == REG_TOTAL) begin
      dec_total = val;
      restart_decode();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until the stream is drained and every beat has come back, or DRAIN_LIMIT runs out
  task automatic settle();
    int waited;
    waited = 0;
    while ((stream_bytes.size() > 0 || in_valid || pending_beats.size() > 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    int roll;
    int cnt;
    int start;
    dec_bpp   = BPP_RESET;
    dec_total = TOTAL_RESET;
    restart_decode();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: single-pixel run finishes the image, then a byte is dropped
    push_byte(8'h80);
    push_pixel(32'h00AA00FF);
    push_byte(8'h3C);
    settle();

    write_reg(REG_TOTAL, 32'd0);
    push_byte(8'h85);
    settle();

    write_reg(REG_BPP, 32'd4);
    write_reg(REG_TOTAL, 32'd200);
    push_byte(8'hFF);
    push_pixel(32'hFFFFFFFF);
    settle();

    write_reg(REG_BPP, 32'd0);
    write_reg(REG_TOTAL, 32'd5);
    push_byte(8'h87);
    push_byte(8'h5A);
    push_byte(8'h7F);
    settle();

    write_reg(REG_BPP, 32'd2);
    write_reg(REG_TOTAL, 32'd3);
    push_byte(8'h04);
    push_pixel(32'h0000);
    push_pixel(32'hFFFF);
    push_pixel(32'h1234);
    push_byte(8'hC3);
    settle();

    write_reg(REG_SPARE_A, 32'hFFFFFFFF);
    write_reg(REG_SPARE_B, 32'h0);
    push_byte(8'h00);
    settle();

    write_reg(REG_BPP, 32'd7);
    write_reg(REG_TOTAL, 32'd2);
    push_byte(8'h81);
    push_pixel(32'hC0FFEE11);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_BPP, 32'($urandom_range(0, 7)));
      case ($urandom_range(0, 3))
        0:       write_reg(REG_TOTAL, 32'hFFFFFFFF);
        1:       write_reg(REG_TOTAL, 32'($urandom_range(1, 40)));
        2:       write_reg(REG_TOTAL, 32'($urandom_range(100, 400)));
        default: write_reg(REG_TOTAL, $urandom());
      endcase
      start = queued_bytes;
      while (queued_bytes - start < PHASE_BYTES) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          push_byte(BYTE_W'($urandom_range(0, 255)));
        end else if (roll < 14) begin
          push_byte(BYTE_W'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
        end else if (roll < 55) begin
          cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 128) : $urandom_range(1, 8);
          push_packet(1'b1, cnt);
        end else begin
          push_packet(1'b0, $urandom_range(1, 6));
        end
      end
      settle();
    end

    if (pending_beats.size() > 0) begin
      errors += pending_beats.size();
      $display("%0t: %0d beats never arrived, expected first %h, actual none",
               $time, pending_beats.size(), pending_beats[0].first);
    end
    $display("Covered %0d stream bytes and %0d pixel beats over %0d register writes,",
             bytes_taken, beats_seen, reg_writes);
    $display("with pixel sizes 1 to 4 bytes, runs, literals and image-end cut-offs.");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/tgarle_pkg.sv
rtl/tgarle_count_unit.sv
rtl/tga_rle_decoder.sv
rtl/tgarle_checker.sv
tb/tb_top.sv
